/* hw/rtl/lfu_pkg.sv */
// Package for the LFU cache table: transaction payload types, opcodes and
// configuration constants. No dependencies.
`default_nettype none

package lfu_pkg;

  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int ACTIVE_W = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [KEY_W-1:0]          lookup_key;
    logic signed [VALUE_W-1:0] put_value;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [VALUE_W-1:0] read_value;
    logic                      evicted;
    logic [KEY_W-1:0]          evicted_key;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/lfu_stream_if.sv */
// Valid/ready stream interface used for the request and response channels.
// Payload type is a parameter; depends on nothing else.
`default_nettype none

interface lfu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lfu_cache_table_core.sv */
// LFU cache table with LRU tie-break: slot registers, lookup/replace logic
// and response register. Depends on lfu_pkg and lfu_stream_if.
//
// Usage:
//   req (sink, lfu_pkg::req_t): one get or put per transaction.
//   rsp (source, lfu_pkg::rsp_t): exactly one response per request, in order.
//   cfg_write_en/cfg_write_data: sets active_entries (capacity); write only
//   while the block is idle. Zero acts as one, values above CAPACITY act as
//   CAPACITY.
// Timing:
//   A request is looked up, and the slot state updated, in the cycle it is
//   accepted; its response appears in the response register on the next
//   cycle. One request per cycle is sustained while responses are taken: the
//   parallel key compare and the all-pairs count/recency victim select over
//   every slot are combinational.
// Reset (rst, synchronous): all slots invalid, active_entries = 8, no
//   response pending.
// Stall: while a response waits and rsp.ready is low, req.ready is low; a
//   response that is taken frees the register for a request in the same cycle.
`default_nettype none

module lfu_cache_table_core #(
  parameter int CAPACITY   = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  lfu_stream_if.sink                         req,
  lfu_stream_if.source                       rsp,
  input  wire logic                          cfg_write_en,
  input  wire logic [lfu_pkg::ACTIVE_W-1:0]  cfg_write_data
);
  import lfu_pkg::*;

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam logic [7:0] CAP8 = 8'(CAPACITY);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [ACTIVE_W-1:0] active_entries;

  logic [CAPACITY-1:0]   slot_valid;
  logic [KEY_W-1:0]      slot_key   [CAPACITY];
  logic [VALUE_W-1:0]    slot_value [CAPACITY];
  logic [COUNT_BITS-1:0] slot_count [CAPACITY];
  logic [RANK_W-1:0]     slot_rank  [CAPACITY];

  logic rsp_valid;
  rsp_t rsp_data;

  logic req_fire;
  assign req.ready = !rsp_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // lookup and victim selection
  logic [CAPACITY-1:0] match, hit_oh, victim_oh, free_oh, ins_oh;
  logic                hit_any, need_evict;
  logic [RANK_W-1:0]   hit_rank, victim_rank;
  logic [VALUE_W-1:0]  hit_value;
  logic [KEY_W-1:0]    victim_key;
  logic [OCC_W-1:0]    occ;
  logic [7:0]          cap_now;

  always_comb begin
    logic seen_hit, seen_free, beats;
    seen_hit    = 1'b0;
    seen_free   = 1'b0;
    hit_rank    = '0;
    hit_value   = '0;
    victim_rank = '0;
    victim_key  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]   = slot_valid[i] && (slot_key[i] == req.data.lookup_key);
      hit_oh[i]  = match[i] && !seen_hit;
      seen_hit   = seen_hit || match[i];
      free_oh[i] = !slot_valid[i] && !seen_free;
      seen_free  = seen_free || !slot_valid[i];
      // slot i is the victim when it beats every other valid slot
      beats = slot_valid[i];
      for (int j = 0; j < CAPACITY; j++) begin
        if (j != i && slot_valid[j] &&
            !((slot_count[i] < slot_count[j]) ||
              (slot_count[i] == slot_count[j] && slot_rank[i] > slot_rank[j]))) begin
          beats = 1'b0;
        end
      end
      victim_oh[i] = beats;
      if (hit_oh[i]) begin
        hit_rank  = slot_rank[i];
        hit_value = slot_value[i];
      end
      if (victim_oh[i]) begin
        victim_rank = slot_rank[i];
        victim_key  = slot_key[i];
      end
    end
    hit_any = |match;
    occ     = OCC_W'($countones(slot_valid));
    if (active_entries == '0) begin
      cap_now = 8'd1;
    end else if (8'(active_entries) > CAP8) begin
      cap_now = CAP8;
    end else begin
      cap_now = 8'(active_entries);
    end
    need_evict = !hit_any && (8'(occ) >= cap_now);
    ins_oh     = need_evict ? victim_oh : free_oh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
    end else if (cfg_write_en) begin
      active_entries <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (req_fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit_any) begin
          if (hit_oh[i]) begin
            if (slot_count[i] != COUNT_MAX) begin
              slot_count[i] <= slot_count[i] + COUNT_BITS'(1);
            end
            slot_rank[i] <= '0;
            if (req.data.op == OP_PUT) begin
              slot_value[i] <= req.data.put_value;
            end
          end else if (slot_valid[i] && slot_rank[i] < hit_rank) begin
            slot_rank[i] <= slot_rank[i] + RANK_W'(1);
          end
        end else if (ins_oh[i]) begin
          slot_valid[i] <= 1'b1;
          slot_key[i]   <= req.data.lookup_key;
          slot_value[i] <= (req.data.op == OP_PUT) ? req.data.put_value : '0;
          slot_count[i] <= COUNT_BITS'(1);
          slot_rank[i]  <= '0;
        end else if (slot_valid[i]) begin
          // close the victim's gap, then age behind the new entry
          if (need_evict && slot_rank[i] > victim_rank) begin
            slot_rank[i] <= slot_rank[i];
          end else begin
            slot_rank[i] <= slot_rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_data.hit         <= hit_any;
      rsp_data.read_value  <= (hit_any && req.data.op == OP_GET) ? hit_value : '0;
      rsp_data.evicted     <= need_evict;
      rsp_data.evicted_key <= need_evict ? victim_key : '0;
    end
  end

`ifndef ASSERT_OFF
  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("duplicate valid key in table");

  a_victim_onehot: assert property (@(posedge clk) disable iff (rst)
    (req_fire && need_evict) |-> $onehot(victim_oh))
    else $error("victim select not one-hot");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    (req_fire && need_evict) |=> (occ == $past(occ)))
    else $error("eviction changed occupancy");

  a_fill_grows_occ: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !hit_any && !need_evict) |=> (8'(occ) == 8'($past(occ)) + 8'd1))
    else $error("miss without eviction did not add an entry");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.hit && rsp_data.evicted))
    else $error("response shows hit and eviction together");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_lfu_cache_table_core.sv */
// Self-checking testbench for lfu_cache_table_core: drives get/put requests over the
// request stream, predicts each response in-line and compares it on the response stream.
// Depends on lfu_pkg, lfu_stream_if and lfu_cache_table_core.
module tb_lfu_cache_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  localparam int NSLOTS      = 8;
  localparam int USE_BITS    = 4;
  localparam int HOLD_CYCLES = 48;
  localparam int POOL_MAX    = 12;

  logic                clk;
  logic                rst;
  logic                cfg_write_en;
  logic [ACTIVE_W-1:0] cfg_write_data;

  lfu_stream_if #(.payload_t(req_t)) req_if ();
  lfu_stream_if #(.payload_t(rsp_t)) rsp_if ();

  lfu_cache_table_core #(
    .CAPACITY   (NSLOTS),
    .COUNT_BITS (USE_BITS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .req            (req_if),
    .rsp            (rsp_if),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // predictor state
  logic                ent_valid [NSLOTS];
  logic [KEY_W-1:0]    ent_key   [NSLOTS];
  logic [VALUE_W-1:0]  ent_val   [NSLOTS];
  logic [USE_BITS-1:0] ent_uses  [NSLOTS];
  int unsigned         ent_age   [NSLOTS];
  logic [ACTIVE_W-1:0] cap_setting;

  rsp_t             due_responses [$];
  int               mismatch_count = 0;
  int               send_idle_pct  = 0;
  int               recv_idle_pct  = 0;
  int               hold_requests  = 0;
  int               hold_seen      = 0;
  int               hold_left      = 0;
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_used      = POOL_MAX;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Move slot s to the front of the recency order; newer valid slots age by one.
  function automatic void promote(input int s, input int unsigned old_age);
    for (int i = 0; i < NSLOTS; i++) begin
      if (ent_valid[i] && i != s && ent_age[i] < old_age) ent_age[i]++;
    end
    ent_age[s] = 0;
  endfunction

  function automatic rsp_t predict_access(input req_t r);
    rsp_t        res;
    int          found;
    int          victim;
    int          slot;
    int unsigned used;
    int unsigned limit;
    int unsigned vage;
    res    = '0;
    found  = -1;
    victim = -1;
    slot   = -1;
    used   = 0;
    limit  = (cap_setting == 0) ? 1 : ((cap_setting > NSLOTS) ? NSLOTS : cap_setting);
    for (int i = 0; i < NSLOTS; i++) begin
      if (ent_valid[i]) begin
        used++;
        if (ent_key[i] == r.lookup_key && found < 0) found = i;
      end
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (ent_uses[found] != {USE_BITS{1'b1}}) ent_uses[found]++;
      promote(found, ent_age[found]);
      if (r.op == OP_PUT) ent_val[found] = r.put_value;
      else res.read_value = ent_val[found];
    end else begin
      if (used >= limit) begin
        // lowest count first, oldest among equal counts
        for (int i = 0; i < NSLOTS; i++) begin
          if (!ent_valid[i]) continue;
          if (victim < 0 || ent_uses[i] < ent_uses[victim] ||
              (ent_uses[i] == ent_uses[victim] && ent_age[i] > ent_age[victim]))
            victim = i;
        end
        if (victim >= 0) begin
          vage             = ent_age[victim];
          res.evicted      = 1'b1;
          res.evicted_key  = ent_key[victim];
          ent_valid[victim] = 1'b0;
          for (int i = 0; i < NSLOTS; i++) begin
            if (ent_valid[i] && ent_age[i] > vage) ent_age[i]--;
          end
          used--;
          slot = victim;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (!ent_valid[i]) begin
            slot = i;
            break;
          end
        end
      end
      if (slot >= 0) begin
        ent_valid[slot] = 1'b1;
        ent_key[slot]   = r.lookup_key;
        ent_val[slot]   = (r.op == OP_PUT) ? r.put_value : '0;
        ent_uses[slot]  = USE_BITS'(1);
        promote(slot, used + 1);
      end
    end
    return res;
  endfunction

  // Offer one request; returns once the transaction is accepted. Valid stays high.
  task automatic send_access(input logic op, input logic [KEY_W-1:0] key,
                             input logic [VALUE_W-1:0] value);
    req_t r;
    r.op         = op;
    r.lookup_key = key;
    r.put_value  = value;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    due_responses.push_back(predict_access(r));
  endtask

  task automatic wait_quiet();
    req_if.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [ACTIVE_W-1:0] v);
    wait_quiet();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cap_setting = v;
    cfg_write_en <= 1'b0;
  endtask

  task automatic test_count_saturation();
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    ka = 32'h0000_00A5;
    kb = 32'h5A00_0000;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(4'd2);
    send_access(OP_PUT, ka, 32'h1111_1111);
    send_access(OP_PUT, kb, 32'h2222_2222);
    // drive both counts past the top so they stick at max
    for (int i = 0; i < (1 << USE_BITS) + 4; i++)
      send_access(i[0], ka, $urandom());
    for (int i = 0; i < (1 << USE_BITS) + 4; i++)
      send_access(i[0], kb, $urandom());
    // equal saturated counts: the older one goes
    send_access(OP_GET, 32'hC0DE_0001, 32'h0);
    send_access(OP_GET, ka, 32'h0);
    send_access(OP_GET, kb, 32'h0);
  endtask

  task automatic test_extremes();
    write_capacity(4'd8);
    send_access(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_access(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_access(OP_PUT, 32'h0000_0000, 32'h8000_0000);
    send_access(OP_GET, 32'h0000_0000, 32'h0);
    send_access(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(OP_PUT, 32'h0000_0001, 32'hFFFF_FFFF);
    send_access(OP_GET, 32'h0000_0001, 32'h0);
    send_access(OP_PUT, 32'h8000_0000, 32'h0000_0000);
    send_access(OP_PUT, 32'h7FFF_FFFF, 32'h5555_5555);
    send_access(OP_PUT, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_access(OP_PUT, 32'h5555_5555, 32'h0000_0001);
    send_access(OP_GET, 32'h1234_5678, 32'h0);
    send_access(OP_GET, 32'h5555_5555, 32'h0);
    send_access(OP_PUT, 32'hFFFF_FFFF, 32'h0);
  endtask

  // Out-of-range and below-occupancy capacity settings.
  task automatic test_capacity_limits();
    write_capacity(4'd0);
    send_access(OP_GET, 32'h0BAD_0001, 32'h0);
    send_access(OP_PUT, 32'h0BAD_0002, 32'hDEAD_BEEF);
    send_access(OP_GET, 32'h0BAD_0002, 32'h0);
    write_capacity(4'd15);
    send_access(OP_PUT, 32'h0BAD_0003, 32'h0000_0003);
    send_access(OP_GET, 32'h0BAD_0001, 32'h0);
    write_capacity(4'd1);
    send_access(OP_PUT, 32'h0BAD_0004, 32'hFFFF_FFFE);
    send_access(OP_GET, 32'h0BAD_0003, 32'h0);
    write_capacity(4'd4);
    send_access(OP_GET, 32'h0BAD_0004, 32'h0);
    send_access(OP_PUT, 32'h0BAD_0005, 32'h8000_0001);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_MAX; i++) begin
      case ($urandom_range(3))
        0:       key_pool[i] = $urandom_range(15);
        1:       key_pool[i] = 32'hFFFF_FFFF - $urandom_range(15);
        default: key_pool[i] = $urandom();
      endcase
    end
    pool_used = $urandom_range(POOL_MAX, 6);
  endtask

  task automatic send_random_access();
    logic [KEY_W-1:0] key;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_used - 1)];
    else key = $urandom();
    send_access(1'($urandom_range(1)), key, $urandom());
  endtask

  // Receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure();
    write_capacity(4'd8);
    refresh_pool();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int i = 0; i < 30; i++) send_random_access();
  endtask

  task automatic test_random(input int n, input int send_pct, input int recv_pct,
                             input logic [ACTIVE_W-1:0] cap);
    write_capacity(cap);
    refresh_pool();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 99) refresh_pool();
      send_random_access();
    end
  endtask

  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (due_responses.size() == 0) begin
        report_mismatch("response transaction with no request outstanding");
      end else begin
        want = due_responses.pop_front();
        if (rsp_if.data.hit !== want.hit)
          report_mismatch($sformatf("hit got %b expected %b", rsp_if.data.hit, want.hit));
        if (rsp_if.data.read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %h expected %h",
                                    rsp_if.data.read_value, want.read_value));
        if (rsp_if.data.evicted !== want.evicted)
          report_mismatch($sformatf("evicted got %b expected %b",
                                    rsp_if.data.evicted, want.evicted));
        if (rsp_if.data.evicted_key !== want.evicted_key)
          report_mismatch($sformatf("evicted_key got %h expected %h",
                                    rsp_if.data.evicted_key, want.evicted_key));
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    cap_setting    = ACTIVE_RESET;
    for (int i = 0; i < NSLOTS; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = '0;
      ent_val[i]   = '0;
      ent_uses[i]  = '0;
      ent_age[i]   = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_count_saturation();
    test_extremes();
    test_capacity_limits();
    test_backpressure();
    test_random(250, 12, 52, 4'd8);
    test_random(250, 12, 52, 4'd3);
    test_random(250, 52, 12, 4'd6);
    test_random(250, 52, 12, 4'd1);
    test_random(250, 0, 0, 4'd8);
    test_random(250, 0, 0, 4'($urandom_range(15)));

    wait_quiet();
    if (due_responses.size() != 0)
      report_mismatch("responses still outstanding at end of run");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
